// ----- design/nrmc_pkg.sv -----
// Shared types, constants and helper functions for the NMEA RMC field extractor.
// Used by nrmc_front, nrmc_queue, nrmc_back and the top level; no dependencies.
package nrmc_pkg;

   // Byte ring geometry
   localparam int RING_DEPTH = 32;
   localparam int RING_IDX_W = $clog2(RING_DEPTH);

   // Decode queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   // Digits carried per record
   localparam int NUM_DIGITS = 10;
   localparam int NUM_KINDS  = 4;

   typedef logic [7:0]            byte_type;
   typedef logic [3:0]            digit_type;
   typedef logic [RING_IDX_W-1:0] slot_type;

   typedef enum logic [1:0] {
      KIND_TIME = 2'd0,
      KIND_LAT  = 2'd1,
      KIND_LON  = 2'd2,
      KIND_DATE = 2'd3
   } record_kind_type;

   // ASCII codes
   localparam byte_type CHAR_DOLLAR = 8'h24;
   localparam byte_type CHAR_G      = 8'h47;
   localparam byte_type CHAR_P      = 8'h50;
   localparam byte_type CHAR_R      = 8'h52;
   localparam byte_type CHAR_M      = 8'h4D;
   localparam byte_type CHAR_N      = 8'h4E;
   localparam byte_type CHAR_W      = 8'h57;
   localparam byte_type CHAR_ZERO   = 8'h30;
   localparam byte_type CHAR_NINE   = 8'h39;

   // Sentence positions at which a record is complete
   localparam logic [7:0] POS_TIME = 8'd8;
   localparam logic [7:0] POS_LAT  = 8'd26;
   localparam logic [7:0] POS_LON  = 8'd39;
   localparam logic [7:0] POS_DATE = 8'd58;

   localparam slot_type SLOT_LAT_HEMI = slot_type'(25);
   localparam slot_type SLOT_LON_HEMI = slot_type'(6);

   localparam logic [11:0] YEAR_BASE = 12'd2000;

   // Ring slots feeding each digit position, per record kind
   typedef slot_type  slot_map_type [NUM_KINDS][NUM_DIGITS];
   typedef logic [3:0] used_map_type [NUM_KINDS];

   localparam slot_map_type DIGIT_SLOTS = '{
      '{5'd2,  5'd3,  5'd4,  5'd5,  5'd6,  5'd7,  5'd0,  5'd0,  5'd0, 5'd0},
      '{5'd15, 5'd16, 5'd17, 5'd18, 5'd20, 5'd21, 5'd22, 5'd23, 5'd0, 5'd0},
      '{5'd27, 5'd28, 5'd29, 5'd30, 5'd31, 5'd1,  5'd2,  5'd3,  5'd4, 5'd0},
      '{5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25, 5'd0,  5'd0,  5'd0, 5'd0}
   };
   localparam used_map_type DIGITS_USED = '{4'd6, 4'd8, 4'd9, 4'd6};

   // One queued record: kind, digit values, any-bad flag, hemisphere
   typedef struct packed {
      record_kind_type                 kind;
      logic [NUM_DIGITS-1:0][3:0]      digits;
      logic                            bad;
      logic                            hemi;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic      bad;
      digit_type value;
   } digit_result_type;

   // ASCII digit to value; a non-digit is flagged and reads as zero
   function automatic digit_result_type decode_digit(byte_type b);
      digit_result_type r;
      r.bad   = (b < CHAR_ZERO) || (b > CHAR_NINE);
      r.value = r.bad ? 4'd0 : b[3:0];
      return r;
   endfunction

   // Two decimal digits to 0..99
   function automatic logic [6:0] pair_value(digit_type hi, digit_type lo);
      return 7'({hi, 3'b000}) + 7'({hi, 1'b0}) + 7'(lo);
   endfunction

endpackage

// ----- design/nrmc_front.sv -----
// Front end: byte ring, position count, header detection and digit classification.
// Depends on nrmc_pkg; pushes one queue_entry_type per completed record.
module nrmc_front
   import nrmc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  byte_type         req_rx_byte,
   input  queue_status_type q_status,
   output logic             push,
   output queue_entry_type  push_entry
);

   byte_type        ring_ff [RING_DEPTH];
   byte_type        ring_in [RING_DEPTH];
   logic [7:0]      pos_ff;
   logic [7:0]      pos_in;
   logic            active_ff;
   logic            active_in;
   logic            accept;
   logic            header_hit;
   logic            active_eff;
   logic            fire;
   record_kind_type kind;
   slot_type        wr_slot;
   logic [RING_DEPTH-1:0] pre_hdr;
   logic [NUM_DIGITS-1:0][3:0] cand_digits [NUM_KINDS];
   logic [NUM_KINDS-1:0]       cand_bad;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign wr_slot   = pos_ff[RING_IDX_W-1:0];

   // Ring after this transaction's write
   always_comb begin
      for (int i = 0; i < RING_DEPTH; i++) begin
         ring_in[i] = (accept && wr_slot == slot_type'(i)) ? req_rx_byte : ring_ff[i];
      end
   end

   // Per-slot "$GPR" seen in the four slots below it
   always_comb begin
      for (int i = 0; i < RING_DEPTH; i++) begin
         pre_hdr[i] = (ring_ff[slot_type'(i - 4)] == CHAR_DOLLAR) &&
                      (ring_ff[slot_type'(i - 3)] == CHAR_G) &&
                      (ring_ff[slot_type'(i - 2)] == CHAR_P) &&
                      (ring_ff[slot_type'(i - 1)] == CHAR_R);
      end
   end

   assign header_hit = (req_rx_byte == CHAR_M) && pre_hdr[wr_slot];
   assign active_eff = header_hit || active_ff;

   // Position and record trigger
   always_comb begin
      pos_in = header_hit ? 8'd0 : pos_ff + 8'd1;
      fire   = 1'b0;
      kind   = KIND_TIME;
      if (active_eff) begin
         unique case (pos_in)
            POS_TIME: begin fire = 1'b1; kind = KIND_TIME; end
            POS_LAT:  begin fire = 1'b1; kind = KIND_LAT;  end
            POS_LON:  begin fire = 1'b1; kind = KIND_LON;  end
            POS_DATE: begin fire = 1'b1; kind = KIND_DATE; end
            default:  begin fire = 1'b0; kind = KIND_TIME; end
         endcase
      end
      active_in = active_eff && !(fire && kind == KIND_DATE);
   end

   // Digit candidates for every kind, from fixed slots
   always_comb begin
      digit_result_type dr;
      for (int k = 0; k < NUM_KINDS; k++) begin
         cand_digits[k] = '0;
         cand_bad[k]    = 1'b0;
         for (int j = 0; j < NUM_DIGITS; j++) begin
            dr = decode_digit(ring_in[DIGIT_SLOTS[k][j]]);
            if (4'(j) < DIGITS_USED[k]) begin
               cand_digits[k][j] = dr.value;
               cand_bad[k]       = cand_bad[k] | dr.bad;
            end
         end
      end
   end

   // Queue entry for the triggered kind
   always_comb begin
      push_entry.kind   = kind;
      push_entry.digits = cand_digits[kind];
      push_entry.bad    = cand_bad[kind];
      unique case (kind)
         KIND_LAT: push_entry.hemi = (ring_in[SLOT_LAT_HEMI] == CHAR_N);
         KIND_LON: push_entry.hemi = (ring_in[SLOT_LON_HEMI] == CHAR_W);
         default:  push_entry.hemi = 1'b0;
      endcase
   end

   assign push = accept && fire;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= 8'd0;
         active_ff <= 1'b0;
         for (int i = 0; i < RING_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
      end else if (accept) begin
         pos_ff    <= pos_in;
         active_ff <= active_in;
         ring_ff   <= ring_in;
      end
   end

   // Header restarts the sentence
   assert property (@(posedge clock) disable iff (reset)
      (accept && header_hit) |=> (pos_ff == 8'd0 && active_ff))
      else $error("header did not restart the sentence");

   // Never push into a full queue
   assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("push while queue full");

endmodule

// ----- design/nrmc_queue.sv -----
// Short FIFO of decoded-digit records between front and back.
// Depends on nrmc_pkg for the entry type and depth.
module nrmc_queue
   import nrmc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  queue_entry_type  push_entry,
   input  logic             pop,
   output queue_entry_type  head_entry,
   output queue_status_type status
);

   queue_entry_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff;
   logic [QPTR_W-1:0]     wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff;
   logic [QPTR_W-1:0]     rd_ptr_in;
   logic [QCOUNT_W-1:0]   count_ff;
   logic [QCOUNT_W-1:0]   count_in;
   logic                  do_push;
   logic                  do_pop;

   assign status.full  = (count_ff == QCOUNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_entry   = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCOUNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCOUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // Occupancy stays within depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCOUNT_W'(QUEUE_DEPTH))
      else $error("queue count overflow");

endmodule

// ----- design/nrmc_back.sv -----
// Back end: turns queued digit records into field values and holds the result register.
// Depends on nrmc_pkg; takes the UTC hour offset from the top level.
module nrmc_back
   import nrmc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic signed [5:0] utc_offset,
   input  queue_entry_type  head_entry,
   input  queue_status_type q_status,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_record_kind,
   output logic [9:0]       rsp_value_a,
   output logic [6:0]       rsp_value_b,
   output logic [11:0]      rsp_value_c,
   output logic [6:0]       rsp_value_d,
   output logic             rsp_hemisphere,
   output logic             rsp_format_error
);

   logic            valid_ff;
   record_kind_type kind_ff;
   logic [9:0]      value_a_ff;
   logic [9:0]      value_a_in;
   logic [6:0]      value_b_ff;
   logic [6:0]      value_b_in;
   logic [11:0]     value_c_ff;
   logic [11:0]     value_c_in;
   logic [6:0]      value_d_ff;
   logic [6:0]      value_d_in;
   logic            hemi_ff;
   logic            error_ff;
   logic [6:0]      pair01;
   logic [6:0]      pair23;
   logic [6:0]      pair34;
   logic [6:0]      pair45;
   logic [6:0]      pair56;
   logic [6:0]      pair67;
   logic [6:0]      pair78;
   logic [8:0]      hour_sum;
   logic [8:0]      hour_r1;
   logic [8:0]      hour_r2;
   logic [8:0]      hour_r3;
   logic [9:0]      lon_deg;

   assign pop = !q_status.empty && (!valid_ff || rsp_ready);

   assign pair01 = pair_value(head_entry.digits[0], head_entry.digits[1]);
   assign pair23 = pair_value(head_entry.digits[2], head_entry.digits[3]);
   assign pair34 = pair_value(head_entry.digits[3], head_entry.digits[4]);
   assign pair45 = pair_value(head_entry.digits[4], head_entry.digits[5]);
   assign pair56 = pair_value(head_entry.digits[5], head_entry.digits[6]);
   assign pair67 = pair_value(head_entry.digits[6], head_entry.digits[7]);
   assign pair78 = pair_value(head_entry.digits[7], head_entry.digits[8]);

   // Hour plus offset, biased by 48 to stay positive, then reduced modulo 24
   always_comb begin
      hour_sum = 9'(pair01) + 9'({{3{utc_offset[5]}}, utc_offset}) + 9'd48;
      hour_r1  = (hour_sum >= 9'd96) ? hour_sum - 9'd96 : hour_sum;
      hour_r2  = (hour_r1 >= 9'd48) ? hour_r1 - 9'd48 : hour_r1;
      hour_r3  = (hour_r2 >= 9'd24) ? hour_r2 - 9'd24 : hour_r2;
   end

   // Three-digit longitude degrees
   assign lon_deg = 10'(pair01) * 10'd10 + 10'(head_entry.digits[2]);

   // Field values per kind, zeroed on a bad digit
   always_comb begin
      value_d_in = 7'd0;
      unique case (head_entry.kind)
         KIND_TIME: begin
            value_a_in = 10'(hour_r3);
            value_b_in = pair23;
            value_c_in = 12'(pair45);
         end
         KIND_LAT: begin
            value_a_in = 10'(pair01);
            value_b_in = pair23;
            value_c_in = 12'(pair45);
            value_d_in = pair67;
         end
         KIND_LON: begin
            value_a_in = lon_deg;
            value_b_in = pair34;
            value_c_in = 12'(pair56);
            value_d_in = pair78;
         end
         KIND_DATE: begin
            value_a_in = 10'(pair01);
            value_b_in = pair23;
            value_c_in = 12'(pair45) + YEAR_BASE;
         end
      endcase
      if (head_entry.bad) begin
         value_a_in = '0;
         value_b_in = '0;
         value_c_in = '0;
         value_d_in = '0;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff    <= head_entry.kind;
         value_a_ff <= value_a_in;
         value_b_ff <= value_b_in;
         value_c_ff <= value_c_in;
         value_d_ff <= value_d_in;
         hemi_ff    <= head_entry.hemi;
         error_ff   <= head_entry.bad;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_record_kind  = kind_ff;
   assign rsp_value_a      = value_a_ff;
   assign rsp_value_b      = value_b_ff;
   assign rsp_value_c      = value_c_ff;
   assign rsp_value_d      = value_d_ff;
   assign rsp_hemisphere   = hemi_ff;
   assign rsp_format_error = error_ff;

   // Wrapped hour always lands in 0..23
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff == KIND_TIME) |-> (value_a_ff < 10'd24))
      else $error("hour out of range");

   // A bad digit clears every value field
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && error_ff) |->
         (value_a_ff == '0 && value_b_ff == '0 && value_c_ff == '0 && value_d_ff == '0))
      else $error("values not cleared on format error");

endmodule

// ----- design/nmea_rmc_field_extractor.sv -----
// Top level of the NMEA RMC field extractor: offset register, front, queue, back.
// Depends on nrmc_pkg, nrmc_front, nrmc_queue and nrmc_back.
//
//   port group   direction  handshake          payload
//   req_         in         req_valid/ready    req_rx_byte (8b)
//   rsp_         out        rsp_valid/ready    kind, value_a..d, hemisphere, format_error
//   csr_         in         csr_wr_en          csr_utc_offset_hours (6b signed)
//
// One byte is accepted per cycle while req_ready is high; the byte that completes a
// record writes it into the queue, and from there it is loaded into the result register.
// Reset is synchronous and clears ring, position, active flag, queue and offset.
// req_ready drops only while the two-entry record queue is full, i.e. when the
// result register has been stalled by rsp_ready long enough for two records to wait.
module nmea_rmc_field_extractor
   import nrmc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_record_kind,
   output logic [9:0]        rsp_value_a,
   output logic [6:0]        rsp_value_b,
   output logic [11:0]       rsp_value_c,
   output logic [6:0]        rsp_value_d,
   output logic              rsp_hemisphere,
   output logic              rsp_format_error,
   input  logic              csr_wr_en,
   input  logic signed [5:0] csr_utc_offset_hours
);

   logic signed [5:0] offset_ff;
   logic              push;
   logic              pop;
   queue_entry_type   push_entry;
   queue_entry_type   head_entry;
   queue_status_type  q_status;

   // UTC offset register
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else if (csr_wr_en) begin
         offset_ff <= csr_utc_offset_hours;
      end
   end

   nrmc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .q_status    (q_status),
      .push        (push),
      .push_entry  (push_entry)
   );

   nrmc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   nrmc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .utc_offset       (offset_ff),
      .head_entry       (head_entry),
      .q_status         (q_status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_record_kind  (rsp_record_kind),
      .rsp_value_a      (rsp_value_a),
      .rsp_value_b      (rsp_value_b),
      .rsp_value_c      (rsp_value_c),
      .rsp_value_d      (rsp_value_d),
      .rsp_hemisphere   (rsp_hemisphere),
      .rsp_format_error (rsp_format_error)
   );

endmodule
